[design/isqrt128_pkg.sv]
// Shared widths, field positions and codes of the 128-bit square root block.
`timescale 1ns / 1ps

package isqrt128_pkg;

    localparam int RAD_W   = 128;  // radicand width
    localparam int HALF_W  = 64;   // one limb
    localparam int ROOT_W  = 64;   // root width, also the number of digit steps
    localparam int REM_W   = 66;   // stored partial remainder, at most 2 * root
    localparam int TRY_W   = 68;   // shifted partial remainder before the trial subtract
    localparam int LIMBS_W = 2;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 136;

    // Remainder limb counts.
    localparam logic [LIMBS_W-1:0] LIMBS_ZERO = 2'd0;
    localparam logic [LIMBS_W-1:0] LIMBS_ONE  = 2'd1;
    localparam logic [LIMBS_W-1:0] LIMBS_TWO  = 2'd2;

    // Bit positions of the result fields in m_tdata.
    localparam int M_ROOT_LSB    = 0;
    localparam int M_REMLO_LSB   = 64;
    localparam int M_REMHI_BIT   = 128;
    localparam int M_LIMBS_LSB   = 129;
    localparam int M_INEXACT_BIT = 131;

endpackage

[design/isqrt128_with_remainder_top.sv]
// Pipelined 128-bit integer square root with remainder, one digit step per stage.
`timescale 1ns / 1ps

// Usage:
// The s_ channel carries one 128-bit radicand per beat, a_high in s_tdata[63:0] and
// a_low in s_tdata[127:64]. The m_ channel returns one result beat per radicand, in
// order: the floor root, the 65-bit remainder split into rem_low and rem_high, the
// remainder limb count and an inexact flag.
// The root is built by a restoring digit recurrence that takes two radicand bits per
// step. Each of the 64 steps has its own register stage, so a new radicand can enter
// every cycle and the sustained rate is one beat per cycle unless m_tready stalls the pipe.
// An accepted input beat passes one input stage and then 64 step stages, each set by one
// 68-bit compare and subtract, before the matching result shows on m_tvalid.
// When the receiver holds m_tready low while a result is shown, the whole pipeline
// holds. A one-beat skid register at the input keeps s_tready a registered signal; it
// catches a beat that arrives during a stall and is drained first when the pipeline
// moves again.
// A synchronous active-low reset on aresetn clears every stage valid bit and the skid
// valid flag, so no result is shown afterward until new radicands arrive.
module isqrt128_with_remainder_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_high [63:0], a_low [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // root, rem_low, rem_high, rem_limbs, inexact, zero fill
);

    localparam int NSTEP = isqrt128_pkg::ROOT_W;

    logic                                   en;
    logic                                   s_acc;
    logic                                   skid_valid_reg;
    logic [isqrt128_pkg::S_TDATA_W-1:0]     skid_data_reg;
    logic [isqrt128_pkg::S_TDATA_W-1:0]     load_data;

    logic [NSTEP:0]                         valid_reg;
    logic [isqrt128_pkg::RAD_W-1:0]         rad_reg   [0:NSTEP-1];
    logic [isqrt128_pkg::ROOT_W-1:0]        root_reg  [0:NSTEP];
    logic [isqrt128_pkg::REM_W-1:0]         rem_reg   [0:NSTEP];

    logic [isqrt128_pkg::RAD_W-1:0]         rad_next  [0:NSTEP-1];
    logic [isqrt128_pkg::ROOT_W-1:0]        root_next [0:NSTEP-1];
    logic [isqrt128_pkg::REM_W-1:0]         rem_next  [0:NSTEP-1];

    logic [isqrt128_pkg::REM_W-1:0]         rem_out;
    logic [isqrt128_pkg::LIMBS_W-1:0]       limbs;
    logic                                   rem_hi_nz;
    logic                                   rem_lo_nz;

    assign en       = !valid_reg[NSTEP] || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    // The radicand arrives with a_high in the low half of the beat.
    assign load_data = skid_valid_reg ? skid_data_reg : s_tdata;

    // One restoring step per stage: shift in the next bit pair, try 4 * root + 1.
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic [isqrt128_pkg::TRY_W-1:0] r4;
        logic [isqrt128_pkg::TRY_W-1:0] trial;
        logic [isqrt128_pkg::TRY_W-1:0] diff;
        logic                           ge;

        always_comb begin
            r4    = {rem_reg[k], rad_reg[k][isqrt128_pkg::RAD_W-1 -: 2]};
            trial = {2'b00, root_reg[k], 2'b01};
            diff  = r4 - trial;
            ge    = (r4 >= trial);
            rem_next[k]  = ge ? diff[isqrt128_pkg::REM_W-1:0] : r4[isqrt128_pkg::REM_W-1:0];
            root_next[k] = {root_reg[k][isqrt128_pkg::ROOT_W-2:0], ge};
            rad_next[k]  = {rad_reg[k][isqrt128_pkg::RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[NSTEP-1:0], skid_valid_reg || s_acc};
            end
            if (skid_valid_reg && en) begin
                skid_valid_reg <= 1'b0;
            end else if (s_acc && !en) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !en) begin
            skid_data_reg <= s_tdata;
        end
        if (en) begin
            rad_reg[0]  <= {load_data[isqrt128_pkg::HALF_W-1:0],
                            load_data[isqrt128_pkg::RAD_W-1:isqrt128_pkg::HALF_W]};
            root_reg[0] <= '0;
            rem_reg[0]  <= '0;
            for (int k = 0; k < NSTEP; k++) begin
                root_reg[k+1] <= root_next[k];
                rem_reg[k+1]  <= rem_next[k];
            end
            for (int k = 0; k < NSTEP - 1; k++) begin
                rad_reg[k+1] <= rad_next[k];
            end
        end
    end

    assign rem_out   = rem_reg[NSTEP];
    assign rem_hi_nz = |rem_out[isqrt128_pkg::REM_W-1:isqrt128_pkg::HALF_W];
    assign rem_lo_nz = |rem_out[isqrt128_pkg::HALF_W-1:0];

    always_comb begin
        if (rem_hi_nz) begin
            limbs = isqrt128_pkg::LIMBS_TWO;
        end else if (rem_lo_nz) begin
            limbs = isqrt128_pkg::LIMBS_ONE;
        end else begin
            limbs = isqrt128_pkg::LIMBS_ZERO;
        end
    end

    assign m_tvalid = valid_reg[NSTEP];
    assign m_tdata  = {4'b0000,
                       rem_hi_nz || rem_lo_nz,
                       limbs,
                       rem_out[isqrt128_pkg::HALF_W],
                       rem_out[isqrt128_pkg::HALF_W-1:0],
                       root_reg[NSTEP]};

endmodule

[design/isqrt128_chk.sv]
// Port-level checker for the square root block and its bind to the top level.
`timescale 1ns / 1ps

module isqrt128_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);

    logic [63:0] root_f;
    logic [63:0] rem_lo_f;
    logic        rem_hi_f;
    logic [1:0]  limbs_f;
    logic        inexact_f;

    assign root_f    = m_tdata[isqrt128_pkg::M_ROOT_LSB +: 64];
    assign rem_lo_f  = m_tdata[isqrt128_pkg::M_REMLO_LSB +: 64];
    assign rem_hi_f  = m_tdata[isqrt128_pkg::M_REMHI_BIT];
    assign limbs_f   = m_tdata[isqrt128_pkg::M_LIMBS_LSB +: 2];
    assign inexact_f = m_tdata[isqrt128_pkg::M_INEXACT_BIT];

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The inexact flag matches a nonzero remainder.
    a_inexact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (inexact_f == (rem_hi_f || (rem_lo_f != 64'd0))))
        else $error("inexact flag disagrees with remainder");

    // The limb count follows the remainder halves.
    a_limbs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rem_hi_f ? (limbs_f == isqrt128_pkg::LIMBS_TWO)
                     : (rem_lo_f != 64'd0) ? (limbs_f == isqrt128_pkg::LIMBS_ONE)
                     : (limbs_f == isqrt128_pkg::LIMBS_ZERO)))
        else $error("remainder limb count is wrong");

    // The remainder is at most twice the root, so a carry into bit 64 needs a large root.
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && rem_hi_f |-> root_f[63])
        else $error("remainder exceeds twice the root");

endmodule

bind isqrt128_with_remainder_top isqrt128_chk u_isqrt128_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/isqrt128_result_monitor.sv]
// Monitor for the 128-bit square root block: predicts every radicand beat and checks results.
`timescale 1ns / 1ps

module isqrt128_result_monitor
    import isqrt128_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // a_high, a_low
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // root, rem_low, rem_high, rem_limbs, inexact
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [HALF_W-1:0]  rem_low;
        logic               rem_high;
        logic [LIMBS_W-1:0] rem_limbs;
        logic               inexact;
    } sqrt_result_t;

    sqrt_result_t root_queue[$];
    int           mismatches = 0;

    // Restoring recurrence: two radicand bits per step, trial subtrahend 4 * root + 1.
    function automatic sqrt_result_t predict_root(input logic [HALF_W-1:0] a_high,
                                                  input logic [HALF_W-1:0] a_low);
        logic [RAD_W-1:0]  radicand;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rest;
        logic [TRY_W-1:0]  partial;
        logic [TRY_W-1:0]  trial;
        sqrt_result_t      res;
        radicand = {a_high, a_low};
        root     = '0;
        rest     = '0;
        for (int step = ROOT_W - 1; step >= 0; step--) begin
            partial = {rest, radicand[2*step +: 2]};
            trial   = {2'b00, root, 2'b01};
            if (partial >= trial) begin
                rest = REM_W'(partial - trial);
                root = {root[ROOT_W-2:0], 1'b1};
            end else begin
                rest = partial[REM_W-1:0];
                root = {root[ROOT_W-2:0], 1'b0};
            end
        end
        res.root      = root;
        res.rem_low   = rest[HALF_W-1:0];
        res.rem_high  = rest[HALF_W];
        res.rem_limbs = (rest[REM_W-1:HALF_W] != 0) ? LIMBS_TWO :
                        (rest[HALF_W-1:0] != 0)     ? LIMBS_ONE : LIMBS_ZERO;
        res.inexact   = (rest != 0);
        return res;
    endfunction

    task automatic check_field(input string label, input logic [HALF_W-1:0] want,
                               input logic [HALF_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        sqrt_result_t want;
        sqrt_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                root_queue.push_back(predict_root(s_tdata[HALF_W-1:0],
                                                  s_tdata[2*HALF_W-1:HALF_W]));
            if (m_tvalid && m_tready) begin
                got.root      = m_tdata[M_ROOT_LSB +: ROOT_W];
                got.rem_low   = m_tdata[M_REMLO_LSB +: HALF_W];
                got.rem_high  = m_tdata[M_REMHI_BIT];
                got.rem_limbs = m_tdata[M_LIMBS_LSB +: LIMBS_W];
                got.inexact   = m_tdata[M_INEXACT_BIT];
                if (root_queue.size() == 0) begin
                    $display("%0t: result beat with none expected, expected nothing, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = root_queue.pop_front();
                    check_field("root", want.root, got.root);
                    check_field("rem_low", want.rem_low, got.rem_low);
                    check_field("rem_high", HALF_W'(want.rem_high), HALF_W'(got.rem_high));
                    check_field("rem_limbs", HALF_W'(want.rem_limbs), HALF_W'(got.rem_limbs));
                    check_field("inexact", HALF_W'(want.inexact), HALF_W'(got.inexact));
                end
            end
        end
        pending    <= root_queue.size();
        fail_count <= mismatches;
    end

endmodule

[tb/isqrt128_with_remainder_top_tb.sv]
// Testbench top for the 128-bit square root block: clock, reset, radicand stimulus, verdict.
`timescale 1ns / 1ps

module isqrt128_with_remainder_top_tb;
    import isqrt128_pkg::*;

    localparam int          LONG_HOLD   = 200;
    localparam int          DRAIN_WAIT  = 80;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // a_high [63:0], a_low [127:64]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // root, rem_low, rem_high, rem_limbs, inexact

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    logic        bursts_on   = 1'b1;
    logic        hold_req    = 1'b0;
    logic        hold_done   = 1'b0;

    isqrt128_with_remainder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    isqrt128_result_monitor u_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("isqrt128_with_remainder_top verification failed");
            $finish;
        end
    end

    // Result side: short random stalls, plus one long hold-off that backs up the pipeline.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done <= 1'b1;
                m_tready  <= 1'b1;
            end else if (bursts_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_radicand(input logic [HALF_W-1:0] a_high, input logic [HALF_W-1:0] a_low);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a_low, a_high};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mix of plain random values, random magnitudes, and values placed around perfect squares.
    function automatic logic [RAD_W-1:0] pick_radicand();
        logic [ROOT_W-1:0] s;
        logic [RAD_W-1:0]  wide;
        logic [RAD_W-1:0]  noise;
        s     = {$urandom, $urandom};
        noise = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: return noise;
            3: return noise >> $urandom_range(0, RAD_W - 1);
            4: return {{HALF_W{1'b0}}, noise[HALF_W-1:0]};
            5: begin
                wide = RAD_W'(s);
                return wide * wide;
            end
            6: begin
                wide = RAD_W'(s);
                return wide * wide + (wide << 1);
            end
            7: begin
                wide = RAD_W'(s);
                return wide * wide - 1;
            end
            8: begin
                wide = RAD_W'(s >> $urandom_range(0, ROOT_W - 1));
                return wide * wide + (noise % ((wide << 1) + 1));
            end
            default: begin
                if ($urandom_range(0, 1) == 0)
                    return {RAD_W{1'b1}} >> $urandom_range(0, RAD_W - 1);
                return RAD_W'(1) << $urandom_range(0, RAD_W - 1);
            end
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [RAD_W-1:0] rad;
        for (int n = 0; n < count; n++) begin
            rad = pick_radicand();
            send_radicand(rad[RAD_W-1:HALF_W], rad[HALF_W-1:0]);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero, tiny values, both halves at their extremes, exact and near-exact squares.
        send_radicand(64'h0, 64'h0);
        send_radicand(64'h0, 64'h1);
        send_radicand(64'h0, 64'h2);
        send_radicand(64'h0, 64'h3);
        send_radicand(64'h0, 64'h4);
        send_radicand(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_radicand(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_radicand(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_radicand(64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_0000_0001);
        send_radicand(64'hFFFF_FFFF_FFFF_FFFE, 64'h0);
        send_radicand(64'h1, 64'h0);
        send_radicand(64'h4000_0000_0000_0000, 64'h0);
        send_radicand(64'h3FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_radicand(64'h4000_0000_0000_0001, 64'h0);
        send_radicand(64'h8000_0000_0000_0000, 64'h0);
        send_radicand(64'h0, 64'hFFFF_FFFE_0000_0001);
        send_radicand(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
        send_radicand(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_radicand(64'h0, 64'h8000_0000_0000_0000);

        send_random(300);

        // The receiver holds off while beats keep coming, so the input must back up.
        hold_req <= 1'b1;
        send_random(150);

        // Let every result come home before starting again.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        send_random(1000);

        bursts_on <= 1'b0;
        send_random(250);
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0) begin
            $display("isqrt128_with_remainder_top verification clean");
        end else begin
            $display("isqrt128_with_remainder_top verification failed");
        end
        $finish;
    end

endmodule
